// ===== design/swq_pkg.sv =====
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and constants for the sorted insert work queue.
// ----------------------------------------------------------------------------
package swq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int OP_W     = 3;
    localparam int KEY_IO_W = 32;
    localparam int FILL_W   = 9;
    localparam int OFFER_W  = 32;
    localparam int JOBS_W   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_TAKE     = 3'd1,
        OP_STOP     = 3'd2,
        OP_RESET    = 3'd3,
        OP_READ_CLR = 3'd4
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec_item;
    } swq_cmd_t;

endpackage

// ===== design/swq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swq_ctrl
// Handshake controller: captures an input word, issues the execute step once
// the output register is free, and holds output valid until it is taken.
// ----------------------------------------------------------------------------
module swq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output swq_pkg::swq_cmd_t cmd
);

    swq_pkg::state_t state_reg;
    swq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.exec_item = 1'b0;
        unique case (state_reg)
            swq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = swq_pkg::ST_EXEC;
                end
            end
            swq_pkg::ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec_item = 1'b1;
                    state_next    = swq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swq_pkg::ST_IDLE;
            end
        endcase

        if (cmd.exec_item)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = (state_reg == swq_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/swq_datapath.sv =====
// ----------------------------------------------------------------------------
// swq_datapath
// Sorted cell chain with per-cell compare, job and statistics counters, and
// the output word register.
// ----------------------------------------------------------------------------
module swq_datapath
#(
    parameter int QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_WIDTH   = swq_pkg::KEY_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  swq_pkg::swq_cmd_t             cmd,
    input  logic [swq_pkg::OP_W-1:0]      op,
    input  logic [swq_pkg::KEY_IO_W-1:0]  key_value,
    input  logic                          done_flag,
    output logic                          ok,
    output logic [swq_pkg::KEY_IO_W-1:0]  key_out,
    output logic [swq_pkg::FILL_W-1:0]    fill_count,
    output logic                          all_idle,
    output logic [swq_pkg::FILL_W-1:0]    peak_fill,
    output logic [swq_pkg::OFFER_W-1:0]   offered_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [swq_pkg::JOBS_W-1:0] JOBS_MAX = '1;

    // captured input word
    swq_pkg::op_t                     op_reg;
    logic [KEY_WIDTH-1:0]             key_reg;
    logic                             done_reg;
    logic [KEY_WIDTH+swq_pkg::KEY_IO_W-1:0] key_in_ext;

    // queue state
    logic [KEY_WIDTH-1:0]             cell_reg  [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0]             cell_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]           lt;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [CW-1:0]                    count_inc;
    logic [CW-1:0]                    peak_reg;
    logic [CW-1:0]                    peak_next;
    logic [swq_pkg::JOBS_W-1:0]       jobs_reg;
    logic [swq_pkg::JOBS_W-1:0]       jobs_next;
    logic [swq_pkg::JOBS_W-1:0]       jobs_ret;
    logic [swq_pkg::OFFER_W-1:0]      offered_reg;
    logic [swq_pkg::OFFER_W-1:0]      offered_next;
    logic                             stopped_reg;
    logic                             stopped_next;
    logic                             ins_en;
    logic                             take_en;
    logic                             ok_c;
    logic [KEY_WIDTH-1:0]             key_c;
    logic [swq_pkg::OFFER_W-1:0]      offered_out_c;

    // output word
    logic                             ok_reg;
    logic [swq_pkg::KEY_IO_W-1:0]     key_out_reg;
    logic [swq_pkg::FILL_W-1:0]       fill_reg;
    logic                             all_idle_reg;
    logic [swq_pkg::FILL_W-1:0]       peak_out_reg;
    logic [swq_pkg::OFFER_W-1:0]      offered_out_reg;
    logic [CW+swq_pkg::FILL_W-1:0]    fill_ext;
    logic [CW+swq_pkg::FILL_W-1:0]    peak_ext;
    logic [KEY_WIDTH+swq_pkg::KEY_IO_W-1:0] key_out_ext;

    assign key_in_ext = {{KEY_WIDTH{1'b0}}, key_value};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= swq_pkg::op_t'(op);
            key_reg  <= key_in_ext[KEY_WIDTH-1:0];
            done_reg <= done_flag;
        end
    end

    // cell chain: keep, insert key, or shift up on add; shift down on take
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(gi);

            assign lt[gi] = (IDX < count_reg) && (cell_reg[gi] < key_reg);

            always_comb
            begin
                cell_next[gi] = cell_reg[gi];
                if (ins_en)
                begin
                    if (lt[gi])
                        cell_next[gi] = cell_reg[gi];
                    else if (gi == 0)
                        cell_next[gi] = key_reg;
                    else if (lt[(gi == 0) ? 0 : gi - 1])
                        cell_next[gi] = key_reg;
                    else
                        cell_next[gi] = cell_reg[(gi == 0) ? 0 : gi - 1];
                end
                else if (take_en && (gi < QUEUE_DEPTH - 1))
                begin
                    cell_next[gi] = cell_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ins_en || take_en)
                    cell_reg[gi] <= cell_next[gi];
            end
        end
    endgenerate

    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        count_next    = count_reg;
        peak_next     = peak_reg;
        jobs_ret      = jobs_reg;
        jobs_next     = jobs_reg;
        offered_next  = offered_reg;
        stopped_next  = stopped_reg;
        ins_en        = 1'b0;
        take_en       = 1'b0;
        ok_c          = 1'b0;
        key_c         = '0;
        offered_out_c = '0;
        if (cmd.exec_item)
        begin
            unique case (op_reg)
                swq_pkg::OP_ADD:
                begin
                    offered_next = offered_reg + swq_pkg::OFFER_W'(1);
                    if (!stopped_reg && (count_reg < DEPTH_C))
                    begin
                        ins_en     = 1'b1;
                        ok_c       = 1'b1;
                        count_next = count_inc;
                        if (count_inc > peak_reg)
                            peak_next = count_inc;
                    end
                end
                swq_pkg::OP_TAKE:
                begin
                    if (done_reg && (jobs_reg != '0))
                        jobs_ret = jobs_reg - swq_pkg::JOBS_W'(1);
                    jobs_next = jobs_ret;
                    if (!stopped_reg && (count_reg != '0))
                    begin
                        take_en    = 1'b1;
                        ok_c       = 1'b1;
                        key_c      = cell_reg[0];
                        count_next = count_reg - CW'(1);
                        if (jobs_ret != JOBS_MAX)
                            jobs_next = jobs_ret + swq_pkg::JOBS_W'(1);
                    end
                end
                swq_pkg::OP_STOP:
                begin
                    stopped_next = 1'b1;
                end
                swq_pkg::OP_RESET:
                begin
                    count_next   = '0;
                    jobs_next    = '0;
                    stopped_next = 1'b0;
                end
                swq_pkg::OP_READ_CLR:
                begin
                    offered_out_c = offered_reg;
                    offered_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            peak_reg    <= '0;
            jobs_reg    <= '0;
            offered_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            peak_reg    <= peak_next;
            jobs_reg    <= jobs_next;
            offered_reg <= offered_next;
            stopped_reg <= stopped_next;
        end
    end

    assign fill_ext    = {{swq_pkg::FILL_W{1'b0}}, count_next};
    assign peak_ext    = {{swq_pkg::FILL_W{1'b0}}, peak_next};
    assign key_out_ext = {{swq_pkg::KEY_IO_W{1'b0}}, key_c};

    always_ff @(posedge clk)
    begin
        if (cmd.exec_item)
        begin
            ok_reg          <= ok_c;
            key_out_reg     <= key_out_ext[swq_pkg::KEY_IO_W-1:0];
            fill_reg        <= fill_ext[swq_pkg::FILL_W-1:0];
            all_idle_reg    <= (count_next == '0) && (jobs_next == '0);
            peak_out_reg    <= peak_ext[swq_pkg::FILL_W-1:0];
            offered_out_reg <= offered_out_c;
        end
    end

    assign ok            = ok_reg;
    assign key_out       = key_out_reg;
    assign fill_count    = fill_reg;
    assign all_idle      = all_idle_reg;
    assign peak_fill     = peak_out_reg;
    assign offered_count = offered_out_reg;

endmodule

// ===== design/sorted_insert_work_queue_top.sv =====
// A word is captured into the input registers, then the single execute step of
// the sorted cell chain registers the result word; the execute step waits while
// an untaken result word is held, and no new word is accepted until it has run.
// Reset (rst_n, async, active low) empties the queue and clears job, peak,
// offered counts and stop; key cells hold no reset value.
// ----------------------------------------------------------------------------
// sorted_insert_work_queue_top
// Bounded ascending-order work queue with job tracking and statistics.
// ----------------------------------------------------------------------------
module sorted_insert_work_queue_top
#(
    parameter int QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_WIDTH   = swq_pkg::KEY_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swq_pkg::OP_W-1:0]      op,
    input  logic [swq_pkg::KEY_IO_W-1:0]  key_value,
    input  logic                          done_flag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [swq_pkg::KEY_IO_W-1:0]  key_out,
    output logic [swq_pkg::FILL_W-1:0]    fill_count,
    output logic                          all_idle,
    output logic [swq_pkg::FILL_W-1:0]    peak_fill,
    output logic [swq_pkg::OFFER_W-1:0]   offered_count
);

    swq_pkg::swq_cmd_t cmd;

    swq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    swq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .key_value     (key_value),
        .done_flag     (done_flag),
        .ok            (ok),
        .key_out       (key_out),
        .fill_count    (fill_count),
        .all_idle      (all_idle),
        .peak_fill     (peak_fill),
        .offered_count (offered_count)
    );

endmodule

// ===== design/swq_checker.sv =====
// ----------------------------------------------------------------------------
// swq_port_checker
// Port-level checks for the sorted insert work queue, bound to the top level.
// ----------------------------------------------------------------------------
module swq_port_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          ok,
    input logic [swq_pkg::KEY_IO_W-1:0]  key_out,
    input logic [swq_pkg::FILL_W-1:0]    fill_count,
    input logic                          all_idle,
    input logic [swq_pkg::FILL_W-1:0]    peak_fill
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while one is in work");

    a_refused_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> key_out == '0)
        else $error("refused word carries a key");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_idle |-> fill_count == '0)
        else $error("idle reported with keys stored");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_count <= peak_fill)
        else $error("fill level above peak");

endmodule

bind sorted_insert_work_queue_top swq_port_checker u_swq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .key_out    (key_out),
    .fill_count (fill_count),
    .all_idle   (all_idle),
    .peak_fill  (peak_fill)
);
